// File: src/spq_pkg.sv
// shared types, codes and sizes for the sorted priority stack
// used by spq_cell and sorted_priority_stack; depends on nothing
package spq_pkg;

  localparam int DEPTH         = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int DATA_BITS     = 32;

  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_POP   = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic                     valid;
    logic [PRIORITY_BITS-1:0] prio;
    logic [DATA_BITS-1:0]     data;
  } entry_t;

  // one command broadcast to every cell in the chain
  typedef struct packed {
    logic                     push;
    logic                     pop;
    logic                     clear;
    logic [PRIORITY_BITS-1:0] prio;
    logic [DATA_BITS-1:0]     data;
  } cmd_t;

endpackage

// File: src/spq_cell.sv
// one slot of the sorted chain: holds an entry and shifts with its neighbors
// depends on spq_pkg
module spq_cell import spq_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  cmd_t   cmd,
  input  entry_t left,
  input  logic   left_stay,
  input  entry_t right,
  output entry_t entry,
  output logic   stay
);

  logic                     valid;
  logic [PRIORITY_BITS-1:0] prio;
  logic [DATA_BITS-1:0]     data;
  logic                     valid_next;
  logic [PRIORITY_BITS-1:0] prio_next;
  logic [DATA_BITS-1:0]     data_next;

  // entry keeps its slot on a push when it outranks the new one
  assign stay  = valid && (prio > cmd.prio);
  assign entry = '{valid: valid, prio: prio, data: data};

  always_comb begin
    valid_next = valid;
    prio_next  = prio;
    data_next  = data;
    if (cmd.clear) begin
      valid_next = 1'b0;
    end else if (cmd.pop) begin
      valid_next = right.valid;
      prio_next  = right.prio;
      data_next  = right.data;
    end else if (cmd.push && !stay) begin
      if (left_stay) begin
        // new item lands here
        valid_next = 1'b1;
        prio_next  = cmd.prio;
        data_next  = cmd.data;
      end else begin
        valid_next = left.valid;
        prio_next  = left.prio;
        data_next  = left.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    prio <= prio_next;
    data <= data_next;
  end

endmodule

// File: src/sorted_priority_stack.sv
// sorted priority stack: chain of DEPTH cells in descending priority order
// depends on spq_pkg and spq_cell
//
// usage:
//   input channel in_valid/in_ready carries action, priority_req and value;
//   action push inserts ahead of every entry of lower or equal priority,
//   pop returns the top entry, clear empties the store.
//   output channel out_valid/out_ready carries data_out, status, is_empty;
//   exactly one result item per input item, in order.
//   the result is registered and shows in the cycle after acceptance.
//   throughput: one item per cycle while results are being taken; every cell
//   compares against the pushed priority in parallel and shifts by one slot.
//   the single output register lets a new item in whenever it is empty or
//   being taken in the same cycle; while the receiver stalls with a result
//   held, in_ready is low and the store does not change.
//   reset: all slots become empty and no result is pending.
//   push to a full store is dropped with status full; pop on empty gives
//   status empty and data_out zero.
module sorted_priority_stack import spq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               action,
  input  logic [PRIORITY_BITS-1:0] priority_req,
  input  logic [DATA_BITS-1:0]     value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [DATA_BITS-1:0]     data_out,
  output logic [1:0]               status,
  output logic                     is_empty
);

  entry_t             cells [DEPTH];
  logic [DEPTH-1:0]   stays;
  logic [DEPTH-1:0]   valid_vec;
  cmd_t               cmd;
  logic               in_fire;
  logic               full;
  logic               top_valid;
  logic [DATA_BITS-1:0] data_res;
  logic [1:0]         status_res;
  logic               empty_res;

  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign full      = cells[DEPTH-1].valid;
  assign top_valid = cells[0].valid;

  assign cmd.push  = in_fire && (action == ACT_PUSH) && !full;
  assign cmd.pop   = in_fire && (action == ACT_POP) && top_valid;
  assign cmd.clear = in_fire && (action == ACT_CLEAR);
  assign cmd.prio  = priority_req;
  assign cmd.data  = value;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   left_s;
    if (i == 0) begin : g_head
      // nothing sits above the top slot, so a push that the top entry does not outrank lands here
      assign left_e = '0;
      assign left_s = 1'b1;
    end else begin : g_body
      assign left_e = cells[i-1];
      assign left_s = stays[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = cells[i+1];
    end
    spq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .left      (left_e),
      .left_stay (left_s),
      .right     (right_e),
      .entry     (cells[i]),
      .stay      (stays[i])
    );
    assign valid_vec[i] = cells[i].valid;
  end

  always_comb begin
    data_res   = '0;
    status_res = STAT_OK;
    empty_res  = !top_valid;
    case (action)
      ACT_PUSH: begin
        empty_res = 1'b0;
        if (full) begin
          status_res = STAT_FULL;
        end
      end
      ACT_POP: begin
        if (top_valid) begin
          data_res  = cells[0].data;
          empty_res = !cells[1].valid;
        end else begin
          status_res = STAT_EMPTY;
          empty_res  = 1'b1;
        end
      end
      ACT_CLEAR: begin
        empty_res = 1'b1;
      end
      default: begin
        empty_res = !top_valid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (in_fire) begin
      data_out <= data_res;
      status   <= status_res;
      is_empty <= empty_res;
    end
  end

`ifndef SYNTH
  logic [DEPTH-1:0] order_ok;
  always_comb begin
    order_ok[0] = 1'b1;
    for (int k = 1; k < DEPTH; k++) begin
      order_ok[k] = !cells[k].valid || (cells[k-1].prio >= cells[k].prio);
    end
  end

  // occupied slots always form one run from the top
  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    $onehot({1'b0, valid_vec} + (DEPTH+1)'(1)))
    else $error("valid slots not contiguous");

  a_sorted: assert property (@(posedge clk) disable iff (rst)
    &order_ok)
    else $error("chain not in descending priority order");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> $countones(valid_vec) == $countones($past(valid_vec)) - 1)
    else $error("pop did not remove exactly one entry");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> $countones(valid_vec) == $countones($past(valid_vec)) + 1)
    else $error("push did not add exactly one entry");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_EMPTY) |-> is_empty && (data_out == '0))
    else $error("empty status with data or non-empty flag");
`endif

endmodule

// File: dv/tb_sorted_priority_stack.sv
// self-checking testbench for sorted_priority_stack: a queue-fed driver, a monitor
// and a cycle-free stack predictor; depends on spq_pkg and the sorted_priority_stack rtl
module tb_sorted_priority_stack;
  import spq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // the one action code the block treats as a no-op
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int RANDOM_OPS = 1600;

  typedef struct packed {
    logic [1:0]               action;
    logic [PRIORITY_BITS-1:0] prio;
    logic [DATA_BITS-1:0]     value;
    logic                     wait_drain;
  } op_t;

  typedef struct packed {
    logic [DATA_BITS-1:0] data_out;
    logic [1:0]           status;
    logic                 is_empty;
  } rsp_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               action = ACT_NONE;
  logic [PRIORITY_BITS-1:0] priority_req = '0;
  logic [DATA_BITS-1:0]     value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [DATA_BITS-1:0]     data_out;
  logic [1:0]               status;
  logic                     is_empty;

  op_t  op_queue[$];
  rsp_t due_results[$];
  int   n_sent;
  int   total_ops;
  int   n_errors;

  // predictor state: slot 0 is the top, slot_count entries are live
  logic [PRIORITY_BITS-1:0] slot_prio[DEPTH];
  logic [DATA_BITS-1:0]     slot_data[DEPTH];
  int                       slot_count;

  sorted_priority_stack dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .priority_req (priority_req),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .data_out     (data_out),
    .status       (status),
    .is_empty     (is_empty)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic rsp_t predict_stack_op(op_t op);
    rsp_t r;
    int   pos;
    r = '0;
    case (op.action)
      ACT_PUSH: begin
        if (slot_count == DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          pos = 0;
          // newest goes ahead of equal priorities
          while (pos < slot_count && slot_prio[pos] > op.prio) pos++;
          for (int i = slot_count; i > pos; i--) begin
            slot_prio[i] = slot_prio[i-1];
            slot_data[i] = slot_data[i-1];
          end
          slot_prio[pos] = op.prio;
          slot_data[pos] = op.value;
          slot_count++;
        end
      end
      ACT_POP: begin
        if (slot_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.data_out = slot_data[0];
          for (int i = 0; i + 1 < slot_count; i++) begin
            slot_prio[i] = slot_prio[i+1];
            slot_data[i] = slot_data[i+1];
          end
          slot_count--;
        end
      end
      ACT_CLEAR: slot_count = 0;
      default: ;
    endcase
    r.is_empty = (slot_count == 0);
    return r;
  endfunction

  function automatic int sender_idle_pct();
    if (n_sent < total_ops / 3) return 8;
    if (n_sent < 2 * total_ops / 3) return 49;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (n_sent < total_ops / 3) return 49;
    if (n_sent < 2 * total_ops / 3) return 8;
    return 0;
  endfunction

  function automatic logic [PRIORITY_BITS-1:0] pick_prio();
    case ($urandom_range(3))
      0: return PRIORITY_BITS'($urandom_range(3));
      1: begin
        case ($urandom_range(3))
          0: return '0;
          1: return '1;
          2: return PRIORITY_BITS'(1);
          default: return {PRIORITY_BITS{1'b1}} - 1'b1;
        endcase
      end
      default: return PRIORITY_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [DATA_BITS-1:0] pick_value();
    case ($urandom_range(15))
      0: return '0;
      1: return '1;
      default: return DATA_BITS'($urandom);
    endcase
  endfunction

  task automatic add_op(logic [1:0] act, logic [PRIORITY_BITS-1:0] p,
                        logic [DATA_BITS-1:0] v, logic hold);
    op_t op;
    op.action     = act;
    op.prio       = p;
    op.value      = v;
    op.wait_drain = hold;
    op_queue.push_back(op);
  endtask

  // driver: presents op_queue[0] and keeps it steady until accepted
  always @(posedge clk) begin : driver
    rsp_t r;
    logic present;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        r = predict_stack_op(op_queue[0]);
        due_results.push_back(r);
        void'(op_queue.pop_front());
        n_sent++;
      end
      if (in_valid && !in_ready) begin
        present = 1'b1;
      end else if (op_queue.size() == 0) begin
        present = 1'b0;
      end else if (op_queue[0].wait_drain && due_results.size() != 0) begin
        present = 1'b0;
      end else begin
        present = ($urandom_range(99) >= sender_idle_pct());
      end
      in_valid <= present;
      if (present && !(in_valid && !in_ready)) begin
        action       <= op_queue[0].action;
        priority_req <= op_queue[0].prio;
        value        <= op_queue[0].value;
      end
    end
  end

  // monitor: checks each accepted result against the oldest prediction
  always @(posedge clk) begin : monitor
    rsp_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("result item with nothing expected: data_out %h status %0d is_empty %0b",
                 data_out, status, is_empty);
          n_errors++;
        end else begin
          want = due_results.pop_front();
          if (data_out !== want.data_out) begin
            $error("data_out mismatch: expected %h, got %h", want.data_out, data_out);
            n_errors++;
          end
          if (status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, status);
            n_errors++;
          end
          if (is_empty !== want.is_empty) begin
            $error("is_empty mismatch: expected %0b, got %0b", want.is_empty, is_empty);
            n_errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= receiver_idle_pct());
    end
  end

  initial begin : stimulus
    int kind;
    int len;
    logic hold;
    n_sent     = 0;
    n_errors   = 0;
    slot_count = 0;

    // directed: empty pop, no-op, extremes, ties, drain past empty, clear
    add_op(ACT_POP,   '0, '0, 1'b0);
    add_op(ACT_NONE,  '1, '1, 1'b0);
    add_op(ACT_PUSH,  '0, '0, 1'b0);
    add_op(ACT_PUSH,  '1, '1, 1'b0);
    add_op(ACT_PUSH,  '1, DATA_BITS'(1), 1'b0);
    add_op(ACT_PUSH,  PRIORITY_BITS'(128), DATA_BITS'(32'ha5a5_a5a5), 1'b0);
    add_op(ACT_POP,   '0, '0, 1'b0);
    add_op(ACT_POP,   '1, '1, 1'b0);
    add_op(ACT_POP,   '0, '0, 1'b0);
    add_op(ACT_POP,   '0, '0, 1'b0);
    add_op(ACT_POP,   '0, '0, 1'b0);
    add_op(ACT_PUSH,  PRIORITY_BITS'(7), DATA_BITS'(32'h1234_5678), 1'b0);
    add_op(ACT_PUSH,  PRIORITY_BITS'(7), DATA_BITS'(32'h8765_4321), 1'b0);
    add_op(ACT_NONE,  '0, '0, 1'b0);
    add_op(ACT_CLEAR, '1, '1, 1'b0);
    add_op(ACT_POP,   '0, '0, 1'b0);
    add_op(ACT_PUSH,  PRIORITY_BITS'(1), DATA_BITS'(32'h5a5a_5a5a), 1'b0);
    add_op(ACT_POP,   '0, '0, 1'b0);

    // random: fill and drain runs with tie-heavy priorities, plus noise
    hold = 1'b1;
    while (op_queue.size() < RANDOM_OPS + 18) begin
      kind = $urandom_range(9);
      if (kind <= 3) begin
        len = $urandom_range(4, 20);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(9) == 0) add_op(ACT_POP, pick_prio(), pick_value(), hold);
          else add_op(ACT_PUSH, pick_prio(), pick_value(), hold);
          hold = 1'b0;
        end
      end else if (kind <= 6) begin
        len = $urandom_range(2, 18);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(9) == 0) add_op(ACT_PUSH, pick_prio(), pick_value(), hold);
          else add_op(ACT_POP, pick_prio(), pick_value(), hold);
          hold = 1'b0;
        end
      end else if (kind == 7) begin
        for (int i = 0; i < 8; i++) begin
          add_op($urandom_range(1) ? ACT_PUSH : ACT_POP, pick_prio(), pick_value(), hold);
          hold = 1'b0;
        end
      end else if (kind == 8) begin
        add_op(ACT_CLEAR, pick_prio(), pick_value(), hold);
      end else begin
        add_op(ACT_NONE, pick_prio(), pick_value(), hold);
        add_op(2'($urandom_range(3)), pick_prio(), pick_value(), 1'b0);
      end
      // now and then hold the next item back until every result is in
      hold = ($urandom_range(19) == 0);
    end
    total_ops = op_queue.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (op_queue.size() != 0 || due_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (n_errors == 0) begin
      $display("[sorted_priority_stack] OK");
    end else begin
      $display("[sorted_priority_stack] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("[sorted_priority_stack] ERROR");
    $finish;
  end

endmodule
